/* rtl/core/swq_pkg.sv */
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and constants of the semaphore wait queue engine.
// ----------------------------------------------------------------------------
`default_nettype none
package swq_pkg;

  localparam int NUM_SEMS = 16;
  localparam int MAX_WAITERS = 32;
  localparam int SEM_W = $clog2(NUM_SEMS);
  localparam int SLOT_W = $clog2(MAX_WAITERS);
  localparam int SCAN_W = SLOT_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;

  localparam logic [5:0] OWNER_NONE = 6'd63;
  localparam logic [31:0] WAIT_FOREVER = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_SEM_LIMIT = 3'd0,
    CFG_USED_MASK = 3'd1,
    CFG_BINARY_MASK = 3'd2,
    CFG_PRIO_MASK = 3'd3,
    CFG_COUNT_MAX = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_INVALID = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_PEND_ISR = 3'd3,
    ST_UNAVAIL = 3'd4,
    ST_PEND_LOCK = 3'd5,
    ST_UNSUPPORTED = 3'd6,
    ST_FULL = 3'd7
  } status_t;

  // classified request handed from front to back
  typedef enum logic [1:0] {
    OP_DONE = 2'd0,    // result already final (invalid, unused)
    OP_PEND = 2'd1,
    OP_POST = 2'd2
  } op_t;

  // pend rejection found by the front, in check order
  typedef enum logic [1:0] {
    PE_NONE = 2'd0,
    PE_ISR = 2'd1,
    PE_ZERO_TMO = 2'd2,
    PE_LOCK = 2'd3
  } pend_err_t;

  typedef struct packed {
    op_t op;
    logic [SEM_W-1:0] sem;
    logic [5:0] task_id;
    logic [5:0] prio;
    pend_err_t pend_err;
    logic unsupported;
    logic prio_mode;
    logic binary;
    logic owner_none;       // invalid id: report no owner
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_WAKE,
    BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

/* rtl/core/swq_if.sv */
// ----------------------------------------------------------------------------
// swq_req_if / swq_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface swq_req_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [7:0] sem_id;
  logic [5:0] task_id;
  logic [5:0] task_priority;
  logic [31:0] timeout;
  logic in_interrupt;
  logic task_locked;
  modport source (output valid, cmd, sem_id, task_id, task_priority, timeout,
                  in_interrupt, task_locked, input ready);
  modport sink (input valid, cmd, sem_id, task_id, task_priority, timeout,
                in_interrupt, task_locked, output ready);
endinterface

interface swq_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic caller_blocks;
  logic woken_valid;
  logic [5:0] woken_task;
  logic [5:0] owner_after;
  modport source (output valid, status, caller_blocks, woken_valid, woken_task,
                  owner_after, input ready);
  modport sink (input valid, status, caller_blocks, woken_valid, woken_task,
                owner_after, output ready);
endinterface
`default_nettype wire

/* rtl/core/swq_front.sv */
// ----------------------------------------------------------------------------
// swq_front
// Checks a request against the configuration and queues a classified job.
// ----------------------------------------------------------------------------
`default_nettype none
module swq_front import swq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  swq_req_if.sink req,
  input  wire logic [4:0] sem_limit,
  input  wire logic [15:0] used_mask,
  input  wire logic [15:0] binary_mask,
  input  wire logic [15:0] prio_mask,
  output job_t job,
  output logic job_valid,
  input  wire logic job_ready
);

  job_t fifo [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0] fill;
  job_t cls;
  logic id_ok;
  logic [SEM_W-1:0] s;
  logic push;
  logic pop;

  assign s = req.sem_id[SEM_W-1:0];
  assign id_ok = ({3'd0, req.sem_id} < {6'd0, sem_limit}) &&
                 ({3'd0, req.sem_id} < 11'(NUM_SEMS));

  always_comb begin
    cls = '0;
    cls.sem = s;
    cls.task_id = req.task_id;
    cls.prio = req.task_priority;
    cls.prio_mode = prio_mask[s];
    cls.binary = binary_mask[s];
    if (!id_ok) begin
      cls.op = OP_DONE;
      cls.owner_none = 1'b1;
    end else if (!used_mask[s]) begin
      cls.op = OP_DONE;
    end else if (req.cmd) begin
      cls.op = OP_POST;
    end else begin
      cls.op = OP_PEND;
      if (req.in_interrupt) cls.pend_err = PE_ISR;
      else if (req.timeout == 32'd0) cls.pend_err = PE_ZERO_TMO;
      else if (req.task_locked) cls.pend_err = PE_LOCK;
      cls.unsupported = (req.timeout != WAIT_FOREVER);
    end
  end

  assign req.ready = (fill != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign push = req.valid && req.ready;
  assign job_valid = (fill != '0);
  assign pop = job_valid && job_ready;
  assign job = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/swq_back.sv */
// ----------------------------------------------------------------------------
// swq_back
// Executes jobs: counts, owners and the waiter table, scanned one slot a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module swq_back import swq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  job_t job,
  input  wire logic job_valid,
  output logic job_ready,
  input  wire logic [15:0] count_max,
  swq_rsp_if.source rsp
);

  bk_state_t state, state_next;

  logic [15:0] sem_count [NUM_SEMS];
  logic [5:0] sem_owner [NUM_SEMS];
  logic [MAX_WAITERS-1:0] waiter_valid;
  // waiter payload memory: task, sem, prio, age
  logic [5+SEM_W+6+16:0] wmem [MAX_WAITERS];
  logic [5+SEM_W+6+16:0] wrd;
  logic [15:0] arrival_counter;

  job_t cur;
  logic [15:0] cnt;
  logic [SCAN_W-1:0] idx;
  logic [SLOT_W-1:0] best;
  logic best_found;
  logic [5:0] best_prio;
  logic [15:0] best_elapsed;
  logic [5:0] best_task_r;
  logic [SLOT_W-1:0] rd_slot;   // slot of wrd
  logic rd_live;
  logic [SLOT_W-1:0] free_slot;
  logic free_found;

  logic [5:0] w_task;
  logic [SEM_W-1:0] w_sem;
  logic [5:0] w_prio;
  logic [15:0] w_age;
  logic [15:0] elapsed;
  logic [5:0] pr;
  logic better;

  // decision of the read state
  logic [15:0] cur_count;
  logic [2:0] rd_status;
  logic [5:0] rd_owner;
  logic rd_take;
  logic rd_queue;
  logic rd_scan;

  logic out_v;
  logic [2:0] o_status;
  logic o_blocks, o_wv;
  logic [5:0] o_wt, o_owner;

  assign {w_task, w_sem, w_prio, w_age} = wrd;
  assign elapsed = arrival_counter - w_age;
  assign pr = cur.prio_mode ? w_prio : 6'd0;
  assign better = !best_found || (pr < best_prio) ||
                  (pr == best_prio && elapsed > best_elapsed);

  // first free slot, priority encoder over valid bits
  always_comb begin
    free_slot = '0;
    free_found = 1'b0;
    for (int i = MAX_WAITERS-1; i >= 0; i--) begin
      if (!waiter_valid[i]) begin
        free_slot = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign cur_count = sem_count[cur.sem];

  always_comb begin
    rd_status = ST_OK;
    rd_owner = sem_owner[cur.sem];
    rd_take = 1'b0;
    rd_queue = 1'b0;
    rd_scan = 1'b0;
    case (cur.op)
      OP_DONE: begin
        rd_status = ST_INVALID;
        if (cur.owner_none) rd_owner = OWNER_NONE;
      end
      OP_PEND: begin
        if (cur.pend_err == PE_ISR) rd_status = ST_PEND_ISR;
        else if (cur_count != 16'd0) begin
          rd_take = 1'b1;
          rd_owner = cur.task_id;
        end else if (cur.pend_err == PE_ZERO_TMO) rd_status = ST_UNAVAIL;
        else if (cur.pend_err == PE_LOCK) rd_status = ST_PEND_LOCK;
        else if (cur.unsupported) rd_status = ST_UNSUPPORTED;
        else if (!free_found) rd_status = ST_FULL;
        else rd_queue = 1'b1;
      end
      OP_POST: begin
        if (cur_count >= count_max) rd_status = ST_OVERFLOW;
        else if (!(cur.binary && cur_count == 16'd1)) rd_scan = 1'b1;
      end
      default: rd_status = ST_INVALID;
    endcase
  end

  assign job_ready = (state == BK_IDLE);
  assign rsp.valid = out_v;
  assign rsp.status = o_status;
  assign rsp.caller_blocks = o_blocks;
  assign rsp.woken_valid = o_wv;
  assign rsp.woken_task = o_wt;
  assign rsp.owner_after = o_owner;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (job_valid) state_next = BK_READ;
      BK_READ: begin
        if (rd_scan) state_next = BK_SCAN;
        else state_next = BK_OUT;
      end
      BK_SCAN: if (idx == SCAN_W'(MAX_WAITERS)) state_next = BK_WAKE;
      BK_WAKE: state_next = BK_OUT;
      BK_OUT: if (rsp.ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // waiter memory read, registered
  always_ff @(posedge clk) begin
    wrd <= wmem[idx[SLOT_W-1:0]];
    rd_slot <= idx[SLOT_W-1:0];
    rd_live <= (state == BK_SCAN) && (idx != SCAN_W'(MAX_WAITERS));
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ && rd_queue)
      wmem[free_slot] <= {cur.task_id, cur.sem, cur.prio, arrival_counter};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_count[i] <= '0;
        sem_owner[i] <= OWNER_NONE;
      end
      waiter_valid <= '0;
      arrival_counter <= '0;
      out_v <= 1'b0;
      idx <= '0;
      best_found <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (job_valid) cur <= job;
          idx <= '0;
          best_found <= 1'b0;
        end
        BK_READ: begin
          cnt <= cur_count;
          o_blocks <= rd_queue;
          o_wv <= 1'b0;
          o_wt <= '0;
          o_status <= rd_status;
          o_owner <= rd_owner;
          if (rd_take) begin
            sem_count[cur.sem] <= cur_count - 16'd1;
            sem_owner[cur.sem] <= cur.task_id;
          end
          if (rd_queue) begin
            waiter_valid[free_slot] <= 1'b1;
            arrival_counter <= arrival_counter + 16'd1;
          end
        end
        BK_SCAN: begin
          if (idx != SCAN_W'(MAX_WAITERS)) idx <= idx + 1'b1;
          if (rd_live && waiter_valid[rd_slot] && w_sem == cur.sem && better) begin
            best <= rd_slot;
            best_found <= 1'b1;
            best_prio <= pr;
            best_elapsed <= elapsed;
          end
        end
        BK_WAKE: begin
          if (best_found) begin
            waiter_valid[best] <= 1'b0;
            o_wv <= 1'b1;
            o_wt <= best_task_r;
            sem_owner[cur.sem] <= best_task_r;
            o_owner <= best_task_r;
          end else begin
            sem_count[cur.sem] <= cnt + 16'd1;
            sem_owner[cur.sem] <= OWNER_NONE;
            o_owner <= OWNER_NONE;
          end
        end
        default: ;
      endcase
      if (state_next == BK_OUT && state != BK_OUT) out_v <= 1'b1;
      else if (state == BK_OUT && rsp.ready) out_v <= 1'b0;
    end
  end

  // task of the best slot, tracked alongside the scan
  always_ff @(posedge clk) begin
    if (state == BK_SCAN && rd_live && waiter_valid[rd_slot] &&
        w_sem == cur.sem && better)
      best_task_r <= w_task;
  end

endmodule
`default_nettype wire

/* rtl/core/semaphore_wait_queue_engine.sv */
// ----------------------------------------------------------------------------
// semaphore_wait_queue_engine
// Counting semaphores with a shared priority/FIFO wait table.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready), one result per request leaves on
// rsp (valid/ready). Configuration registers are written through cfg_we,
// cfg_index and cfg_data while the engine is idle.
// The front checks ids and masks and queues the classified request in a
// two-entry queue; the back executes it one request at a time.
// A pend or rejected request passes the front queue and the back's read
// state before its result shows; a post that gets past the count checks
// scans all 32 waiter slots one per cycle through the waiter memory read
// port, then wakes. The back takes the next request the cycle after a
// result is taken.
// Reset clears counts to zero, owners to none, the waiter valid bits and the
// arrival counter; registers take their reset values.
// When rsp stalls the back holds its result and the front keeps accepting
// until its queue is full.
// ----------------------------------------------------------------------------
`default_nettype none
module semaphore_wait_queue_engine import swq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  swq_req_if.sink req,
  swq_rsp_if.source rsp,
  input  wire logic cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [4:0] sem_limit;
  logic [15:0] used_mask, binary_mask, prio_mask, count_max;
  job_t job;
  logic job_valid, job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_limit <= 5'd16;
      used_mask <= '0;
      binary_mask <= '0;
      prio_mask <= '0;
      count_max <= 16'd65534;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEM_LIMIT: sem_limit <= cfg_data[4:0];
        CFG_USED_MASK: used_mask <= cfg_data;
        CFG_BINARY_MASK: binary_mask <= cfg_data;
        CFG_PRIO_MASK: prio_mask <= cfg_data;
        CFG_COUNT_MAX: count_max <= cfg_data;
        default: ;
      endcase
    end
  end

  swq_front u_front (
    .clk, .rst, .req,
    .sem_limit, .used_mask, .binary_mask, .prio_mask,
    .job, .job_valid, .job_ready
  );

  swq_back u_back (
    .clk, .rst, .job, .job_valid, .job_ready, .count_max, .rsp
  );

endmodule
`default_nettype wire

/* rtl/core/swq_checker.sv */
// ----------------------------------------------------------------------------
// swq_checker
// Port-level checks of the semaphore wait queue engine.
// ----------------------------------------------------------------------------
`default_nettype none
module swq_checker import swq_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [2:0] status,
  input wire logic caller_blocks,
  input wire logic woken_valid,
  input wire logic [5:0] woken_task
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("result dropped while stalled");

  a_block_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && caller_blocks |-> status == ST_OK && !woken_valid)
    else $error("blocking pend with bad status or wake");

  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && woken_valid |-> status == ST_OK && woken_task != OWNER_NONE)
    else $error("wake with bad status");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result after reset");

endmodule

bind semaphore_wait_queue_engine swq_checker u_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .caller_blocks(rsp.caller_blocks),
  .woken_valid(rsp.woken_valid), .woken_task(rsp.woken_task)
);
`default_nettype wire

/* verif/swq_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swq_scoreboard
// Watches the request, result and register ports of the semaphore engine,
// keeps its own copy of counts, owners and the wait table, predicts the
// result of every accepted request and compares it with the engine output.
// ----------------------------------------------------------------------------
module swq_scoreboard import swq_pkg::*; (
  input  logic clk,
  input  logic rst,
  swq_req_if req,
  swq_rsp_if rsp,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int errors,
  output int pending
);

  typedef struct {
    status_t status;
    logic blocks;
    logic woke;
    logic [5:0] woken;
    logic [5:0] owner;
  } sem_result_t;

  logic [4:0] lim;
  logic [15:0] used, bin, prio_mode, cmax;
  logic [15:0] count_tab [NUM_SEMS];
  logic [5:0] owner_tab [NUM_SEMS];
  logic wt_valid [MAX_WAITERS];
  logic [5:0] wt_task [MAX_WAITERS];
  logic [3:0] wt_sem [MAX_WAITERS];
  logic [5:0] wt_prio [MAX_WAITERS];
  logic [15:0] wt_age [MAX_WAITERS];
  logic [15:0] arrivals;

  sem_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic sem_result_t serve_request(input logic cmd, input logic [7:0] s,
      input logic [5:0] tid, input logic [5:0] pr, input logic [31:0] tmo,
      input logic isr, input logic lk);
    sem_result_t r;
    int slot, best;
    logic [15:0] elapsed, best_elapsed;
    logic [5:0] p, best_p;
    logic [3:0] si;
    r.status = ST_OK;
    r.blocks = 0;
    r.woke = 0;
    r.woken = 0;
    r.owner = OWNER_NONE;
    si = s[3:0];
    if (s >= lim || s >= NUM_SEMS) begin
      r.status = ST_INVALID;
    end else if (!used[si]) begin
      r.status = ST_INVALID;
      r.owner = owner_tab[si];
    end else if (cmd == 1'b0) begin
      if (isr) begin
        r.status = ST_PEND_ISR;
      end else if (count_tab[si] > 0) begin
        count_tab[si]--;
        owner_tab[si] = tid;
      end else if (tmo == 0) begin
        r.status = ST_UNAVAIL;
      end else if (lk) begin
        r.status = ST_PEND_LOCK;
      end else if (tmo != WAIT_FOREVER) begin
        // finite timeouts are rejected, caller is not queued
        r.status = ST_UNSUPPORTED;
      end else begin
        slot = -1;
        for (int i = 0; i < MAX_WAITERS; i++)
          if (slot < 0 && !wt_valid[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          wt_valid[slot] = 1;
          wt_task[slot] = tid;
          wt_sem[slot] = si;
          wt_prio[slot] = pr;
          wt_age[slot] = arrivals;
          arrivals++;
          r.blocks = 1;
        end
      end
      r.owner = owner_tab[si];
    end else begin
      if (count_tab[si] >= cmax) begin
        r.status = ST_OVERFLOW;
      end else if (bin[si] && count_tab[si] == 1) begin
        r.status = ST_OK;
      end else begin
        best = -1;
        best_p = 0;
        best_elapsed = 0;
        for (int i = 0; i < MAX_WAITERS; i++) begin
          if (wt_valid[i] && wt_sem[i] == si) begin
            elapsed = arrivals - wt_age[i];
            p = prio_mode[si] ? wt_prio[i] : 6'd0;
            if (best < 0 || p < best_p || (p == best_p && elapsed > best_elapsed)) begin
              best = i;
              best_p = p;
              best_elapsed = elapsed;
            end
          end
        end
        if (best >= 0) begin
          wt_valid[best] = 0;
          r.woke = 1;
          r.woken = wt_task[best];
          owner_tab[si] = wt_task[best];
        end else begin
          count_tab[si]++;
          owner_tab[si] = OWNER_NONE;
        end
      end
      r.owner = owner_tab[si];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sem_result_t e;
    if (rst) begin
      lim = 5'd16;
      used = 0;
      bin = 0;
      prio_mode = 0;
      cmax = 16'd65534;
      for (int i = 0; i < NUM_SEMS; i++) begin
        count_tab[i] = 0;
        owner_tab[i] = OWNER_NONE;
      end
      for (int i = 0; i < MAX_WAITERS; i++) wt_valid[i] = 0;
      arrivals = 0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEM_LIMIT: lim = cfg_data[4:0];
          CFG_USED_MASK: used = cfg_data;
          CFG_BINARY_MASK: bin = cfg_data;
          CFG_PRIO_MASK: prio_mode = cfg_data;
          CFG_COUNT_MAX: cmax = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_results.push_back(serve_request(req.cmd, req.sem_id, req.task_id,
            req.task_priority, req.timeout, req.in_interrupt, req.task_locked));
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d", $time,
                   rsp.status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (rsp.status !== e.status || rsp.caller_blocks !== e.blocks ||
              rsp.woken_valid !== e.woke || rsp.woken_task !== e.woken ||
              rsp.owner_after !== e.owner) begin
            $display("%0t: mismatch exp status %0d blocks %0d woken %0d/%0d owner %0d",
                     $time, e.status, e.blocks, e.woke, e.woken, e.owner);
            $display("%0t:          act status %0d blocks %0d woken %0d/%0d owner %0d",
                     $time, rsp.status, rsp.caller_blocks, rsp.woken_valid,
                     rsp.woken_task, rsp.owner_after);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* verif/semaphore_wait_queue_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// semaphore_wait_queue_engine_test
// Drives pend and post requests through several register settings with
// bursty traffic and receiver stalls; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_engine_test;
  import swq_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int err_count, pending;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;

  swq_req_if req_ch();
  swq_rsp_if rsp_ch();

  semaphore_wait_queue_engine dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  swq_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(err_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd = 1'b0;
    req_ch.sem_id = '0;
    req_ch.task_id = '0;
    req_ch.task_priority = '0;
    req_ch.timeout = '0;
    req_ch.in_interrupt = 1'b0;
    req_ch.task_locked = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern chosen at random from three modes, long hold-off on demand
  initial begin
    int hold_left, cyc, mode;
    logic r;
    hold_left = 0;
    cyc = 0;
    mode = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        r = 1'b0;
      end else begin
        case (mode)
          0: r = 1'b1;
          1: r = 1'($urandom_range(0, 1));
          default: r = (cyc % 7) < 3;
        endcase
      end
      rsp_ch.ready = r;
    end
  end

  task automatic send_req(input logic cmd, input logic [7:0] s, input logic [5:0] tid,
      input logic [5:0] pr, input logic [31:0] tmo, input logic isr, input logic lk);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 4) != 0) begin
        gap = $urandom_range(1, 15);
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.cmd = cmd;
    req_ch.sem_id = s;
    req_ch.task_id = tid;
    req_ch.task_priority = pr;
    req_ch.timeout = tmo;
    req_ch.in_interrupt = isr;
    req_ch.task_locked = lk;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_regs(input logic [4:0] lim, input logic [15:0] used,
      input logic [15:0] bin, input logic [15:0] pmode, input logic [15:0] cmax);
    cfg_we = 1'b1;
    cfg_index = CFG_SEM_LIMIT;
    cfg_data = {11'd0, lim};
    @(negedge clk);
    cfg_index = CFG_USED_MASK;
    cfg_data = used;
    @(negedge clk);
    cfg_index = CFG_BINARY_MASK;
    cfg_data = bin;
    @(negedge clk);
    cfg_index = CFG_PRIO_MASK;
    cfg_data = pmode;
    @(negedge clk);
    cfg_index = CFG_COUNT_MAX;
    cfg_data = cmax;
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  task automatic random_reqs(input int n, input int pend_pct, input bit hold_mid,
      input bit drain_mid);
    logic [7:0] s;
    logic [31:0] tmo;
    int k;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) hold_req = 1'b1;
      if (drain_mid && i == n / 2) wait_drained();
      k = $urandom_range(0, 99);
      s = (k < 85) ? 8'($urandom_range(0, 5)) :
          (k < 95) ? 8'($urandom_range(0, 17)) : 8'($urandom_range(0, 255));
      k = $urandom_range(0, 99);
      tmo = (k < 60) ? WAIT_FOREVER : (k < 75) ? 32'd0 :
            (k < 90) ? $urandom : 32'($urandom_range(1, 9));
      send_req($urandom_range(0, 99) >= pend_pct, s, 6'($urandom_range(0, 62)),
               6'($urandom_range(0, 63)), tmo, $urandom_range(0, 99) < 8,
               $urandom_range(0, 99) < 8);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_regs(5'd16, 16'hFFFF, 16'h0000, 16'h0000, 16'd65534);
    // directed: isr, zero, lock and finite timeout pend rejections, queueing, fifo wake, count path, bad ids
    send_req(1'b0, 8'd0, 6'd5, 6'd1, 32'd0, 1'b0, 1'b0);
    send_req(1'b0, 8'd0, 6'd5, 6'd1, WAIT_FOREVER, 1'b1, 1'b0);
    send_req(1'b0, 8'd0, 6'd5, 6'd1, WAIT_FOREVER, 1'b0, 1'b1);
    send_req(1'b0, 8'd0, 6'd5, 6'd1, 32'd5, 1'b0, 1'b0);
    send_req(1'b0, 8'd0, 6'd1, 6'd9, WAIT_FOREVER, 1'b0, 1'b0);
    send_req(1'b0, 8'd0, 6'd2, 6'd3, WAIT_FOREVER, 1'b0, 1'b0);
    send_req(1'b1, 8'd0, 6'd0, 6'd0, 32'd0, 1'b0, 1'b0);
    send_req(1'b1, 8'd0, 6'd0, 6'd0, 32'd0, 1'b0, 1'b0);
    send_req(1'b1, 8'd0, 6'd0, 6'd0, 32'd0, 1'b0, 1'b0);
    send_req(1'b0, 8'd0, 6'd62, 6'd63, 32'd0, 1'b0, 1'b0);
    send_req(1'b0, 8'd16, 6'd7, 6'd0, WAIT_FOREVER, 1'b0, 1'b0);
    send_req(1'b1, 8'd255, 6'd7, 6'd0, WAIT_FOREVER, 1'b0, 1'b0);
    send_req(1'b1, 8'd3, 6'd62, 6'd63, WAIT_FOREVER, 1'b1, 1'b1);
    send_req(1'b0, 8'd3, 6'd0, 6'd0, 32'hFFFF_FFFE, 1'b1, 1'b1);
    send_req(1'b0, 8'd3, 6'd0, 6'd0, 32'hFFFF_FFFE, 1'b0, 1'b0);
    random_reqs(120, 75, 1'b1, 1'b0);
    wait_drained();

    write_regs(5'd16, 16'hFFFF, 16'h00FF, 16'hFF00, 16'd3);
    random_reqs(120, 50, 1'b0, 1'b0);
    wait_drained();

    write_regs(5'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'd65534);
    random_reqs(30, 50, 1'b0, 1'b0);
    wait_drained();

    write_regs(5'd10, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'd1);
    random_reqs(130, 60, 1'b0, 1'b0);
    wait_drained();

    write_regs(5'd16, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(1, 8)));
    random_reqs(130, 55, 1'b0, 1'b1);
    wait_drained();

    write_regs(5'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd65534);
    random_reqs(130, 70, 1'b1, 1'b0);

    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
